// ===== rtl/cdeq_pkg.sv =====
// cdeq_pkg: command and status codes plus the beat types for the circular deque
// no dependencies; imported by every module of the deque
package cdeq_pkg;

   typedef enum logic [1:0] {
      CMD_PUSH_REAR  = 2'd0,
      CMD_PUSH_FRONT = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_REAR   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   localparam logic signed [31:0] REFUSED_POP_VALUE = -32'sd1;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] push_value;
   } req_beat_type;

   typedef struct packed {
      logic signed [31:0] pop_value;
      logic [1:0]         status;
      logic               empty_now;
      logic               full_now;
   } rsp_beat_type;

   typedef struct packed {
      logic accept;
   } ctrl_cmd_type;

endpackage

// ===== rtl/cdeq_ctrl.sv =====
// cdeq_ctrl: handshake controller, one request beat in flight at a time
// depends on cdeq_pkg; drives cdeq_dpath through ctrl_cmd_type
module cdeq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cdeq_pkg::ctrl_cmd_type ctrl_cmd
);
   import cdeq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_RESP = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_RESP);
   assign ctrl_cmd.accept = (state_ff == S_IDLE) && req_valid;

endmodule

// ===== rtl/cdeq_dpath.sv =====
// cdeq_dpath: slot memory, head and tail pointers and the result register
// depends on cdeq_pkg; commanded by cdeq_ctrl
module cdeq_dpath #(
   parameter int DEPTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cdeq_pkg::ctrl_cmd_type ctrl_cmd,
   input  cdeq_pkg::req_beat_type req_item,
   output cdeq_pkg::rsp_beat_type rsp_item
);
   import cdeq_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

   logic [31:0] slots_mem [DEPTH];

   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic          empty_ff, empty_in;
   logic [31:0]   rd_ff;
   logic [1:0]    status_ff, status_in;
   logic          was_pop_ff;

   logic [PW-1:0] head_next, head_prev, tail_next, tail_prev;
   logic [PW-1:0] wr_addr, rd_addr;
   logic          wr_en, rd_en, is_push, full_cur;

   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign head_prev = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign tail_next = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;

   assign full_cur = !empty_ff && (tail_next == head_ff);
   assign is_push  = (req_item.cmd == CMD_PUSH_REAR) || (req_item.cmd == CMD_PUSH_FRONT);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      status_in = STATUS_DONE;
      wr_en     = 1'b0;
      wr_addr   = '0;
      rd_en     = 1'b0;
      rd_addr   = (req_item.cmd == CMD_POP_FRONT) ? head_ff : tail_ff;
      if (is_push) begin
         if (full_cur) begin
            status_in = STATUS_FULL;
         end else if (empty_ff) begin
            head_in  = '0;
            tail_in  = '0;
            empty_in = 1'b0;
            wr_en    = 1'b1;
         end else if (req_item.cmd == CMD_PUSH_REAR) begin
            tail_in = tail_next;
            wr_addr = tail_next;
            wr_en   = 1'b1;
         end else begin
            head_in = head_prev;
            wr_addr = head_prev;
            wr_en   = 1'b1;
         end
      end else begin
         if (empty_ff) begin
            status_in = STATUS_EMPTY;
         end else begin
            rd_en = 1'b1;
            if (head_ff == tail_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b1;
            end else if (req_item.cmd == CMD_POP_FRONT) begin
               head_in = head_next;
            end else begin
               tail_in = tail_prev;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.accept && wr_en) slots_mem[wr_addr] <= req_item.push_value;
      if (ctrl_cmd.accept && rd_en) rd_ff <= slots_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.accept) begin
         status_ff  <= status_in;
         was_pop_ff <= !is_push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (ctrl_cmd.accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
      end
   end

   always_comb begin
      if (status_ff == STATUS_EMPTY)                rsp_item.pop_value = REFUSED_POP_VALUE;
      else if (was_pop_ff && status_ff == STATUS_DONE) rsp_item.pop_value = rd_ff;
      else                                           rsp_item.pop_value = '0;
   end

   assign rsp_item.status    = status_ff;
   assign rsp_item.empty_now = empty_ff;
   assign rsp_item.full_now  = full_cur;

endmodule

// ===== rtl/circular_double_ended_queue_core.sv =====
// Circular double-ended queue of DEPTH 32-bit words. Each request beat carries a
// command (push rear, push front, pop front, pop rear) and a word; each request
// gives exactly one response beat with the popped word, a status and the empty
// and full flags after the command. One command is handled at a time: a beat is
// taken in one cycle, its response shows in the next and the following request
// is taken in the cycle after the response leaves, so a new command is not taken
// before the last response has left. The result register holds the registered
// read of the slot memory. No clearing pass is needed after reset.
// circular_double_ended_queue_core: top level, joins cdeq_ctrl and cdeq_dpath
// depends on cdeq_pkg
module circular_double_ended_queue_core #(
   parameter int DEPTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cdeq_pkg::req_beat_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cdeq_pkg::rsp_beat_type rsp_item
);
   import cdeq_pkg::*;

   ctrl_cmd_type ctrl_cmd;

   cdeq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl_cmd  (ctrl_cmd)
   );

   cdeq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .ctrl_cmd (ctrl_cmd),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

endmodule

// ===== rtl/cdeq_checker.sv =====
// cdeq_checker: port-level assertions for the circular deque
// depends on cdeq_pkg; bound to circular_double_ended_queue_core
module cdeq_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input cdeq_pkg::rsp_beat_type rsp_item
);
   import cdeq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("response beat dropped or changed while stalled");

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request gave no response beat");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.empty_now && rsp_item.full_now))
      else $error("queue flagged empty and full together");

   a_refused_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == STATUS_EMPTY |->
         rsp_item.empty_now && rsp_item.pop_value == REFUSED_POP_VALUE)
      else $error("refused pop with wrong word or flag");

   a_refused_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == STATUS_FULL |->
         rsp_item.full_now && rsp_item.pop_value == 32'sd0)
      else $error("refused push with wrong word or flag");

endmodule

bind circular_double_ended_queue_core cdeq_checker u_cdeq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

// ===== verif/circular_double_ended_queue_core_tb.sv =====
// circular_double_ended_queue_core_tb: self-checking bench for the circular deque core
// drives command beats, predicts every response beat with a shadow deque, compares them
// depends on cdeq_pkg and circular_double_ended_queue_core
module circular_double_ended_queue_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cdeq_pkg::*;

   localparam int DEPTH      = 8;
   localparam int HOLD_LEN   = 200;
   localparam int CYCLE_CAP  = 500000;
   localparam int SETTLE_CYC = 10;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_beat_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_beat_type rsp_item;

   req_beat_type pending_cmds[$];
   rsp_beat_type predicted_rsps[$];

   logic signed [31:0] shadow_slots [DEPTH];
   int unsigned        shadow_head  = 0;
   int unsigned        shadow_tail  = 0;
   bit                 shadow_empty = 1'b1;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_go        = 1'b0;
   int hold_count     = 0;
   int cycle_count    = 0;
   int error_count    = 0;
   int cmd_count      = 0;
   int rsp_count      = 0;
   int full_refusals  = 0;
   int empty_refusals = 0;
   int last_pops      = 0;

   circular_double_ended_queue_core #(
      .DEPTH(DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

   always #10 clock = ~clock;

   function automatic bit shadow_full();
      return !shadow_empty && ((shadow_tail + 1) % DEPTH == shadow_head);
   endfunction

   // shadow deque: applies one command, returns the response it should give
   function automatic rsp_beat_type deque_apply(req_beat_type beat);
      rsp_beat_type rsp;
      cmd_type      cmd;
      int unsigned  at;
      cmd = cmd_type'(beat.cmd);
      rsp = '0;
      rsp.status = STATUS_DONE;
      if (cmd == CMD_PUSH_REAR || cmd == CMD_PUSH_FRONT) begin
         if (shadow_full()) begin
            rsp.status = STATUS_FULL;
            full_refusals++;
         end else if (shadow_empty) begin
            shadow_head     = 0;
            shadow_tail     = 0;
            shadow_slots[0] = beat.push_value;
            shadow_empty    = 1'b0;
         end else if (cmd == CMD_PUSH_REAR) begin
            shadow_tail = (shadow_tail + 1) % DEPTH;
            shadow_slots[shadow_tail] = beat.push_value;
         end else begin
            shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
            shadow_slots[shadow_head] = beat.push_value;
         end
      end else if (shadow_empty) begin
         rsp.status    = STATUS_EMPTY;
         rsp.pop_value = REFUSED_POP_VALUE;
         empty_refusals++;
      end else begin
         at = (cmd == CMD_POP_FRONT) ? shadow_head : shadow_tail;
         rsp.pop_value = shadow_slots[at];
         if (shadow_head == shadow_tail) begin
            shadow_head  = 0;
            shadow_tail  = 0;
            shadow_empty = 1'b1;
            last_pops++;
         end else if (cmd == CMD_POP_FRONT) begin
            shadow_head = (shadow_head + 1) % DEPTH;
         end else begin
            shadow_tail = (shadow_tail + DEPTH - 1) % DEPTH;
         end
      end
      rsp.empty_now = shadow_empty;
      rsp.full_now  = shadow_full();
      return rsp;
   endfunction

   task automatic flag_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      error_count++;
      $display("mismatch in %s at response %0d: got %h, want %h",
               field, rsp_count, got, want);
   endtask

   task automatic add_cmd(input cmd_type cmd, input logic [31:0] value);
      req_beat_type beat;
      beat.cmd        = cmd;
      beat.push_value = value;
      pending_cmds.push_back(beat);
   endtask

   // bursts of 16 with a push bias drawn per burst, so the deque swings full and empty
   task automatic add_random(input int count);
      int      push_pct;
      cmd_type cmd;
      push_pct = 50;
      for (int i = 0; i < count; i++) begin
         if (i % 16 == 0) begin
            case ($urandom_range(2))
               0: push_pct = 15;
               1: push_pct = 50;
               default: push_pct = 85;
            endcase
         end
         if ($urandom_range(99) < push_pct) begin
            cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
         end else begin
            cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_REAR;
         end
         add_cmd(cmd, $urandom);
      end
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_valid || predicted_rsps.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      @(posedge clock);
      send_idle_pct  <= send_pct;
      recv_stall_pct <= stall_pct;
   endtask

   // command driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_rsps.push_back(deque_apply(req_item));
            cmd_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_item  <= pending_cmds.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (predicted_rsps.size() == 0) begin
               flag_mismatch("response with none pending", rsp_item.pop_value, '0);
            end else begin
               if (rsp_item.pop_value !== predicted_rsps[0].pop_value)
                  flag_mismatch("pop_value", rsp_item.pop_value, predicted_rsps[0].pop_value);
               if (rsp_item.status !== predicted_rsps[0].status)
                  flag_mismatch("status", 32'(rsp_item.status),
                                32'(predicted_rsps[0].status));
               if (rsp_item.empty_now !== predicted_rsps[0].empty_now)
                  flag_mismatch("empty_now", 32'(rsp_item.empty_now),
                                32'(predicted_rsps[0].empty_now));
               if (rsp_item.full_now !== predicted_rsps[0].full_now)
                  flag_mismatch("full_now", 32'(rsp_item.full_now),
                                32'(predicted_rsps[0].full_now));
               void'(predicted_rsps.pop_front());
            end
         end
         rsp_stall <= (hold_go && hold_count < HOLD_LEN) ||
                      ($urandom_range(99) < recv_stall_pct);
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_go) hold_count <= hold_count + 1;
      else hold_count <= 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_idling(0, 0);

      // directed: refusals on empty, pushes into empty from both ends, fill, refusals
      // on full, drain, last-element pops and wrap in both directions
      add_cmd(CMD_POP_FRONT, $urandom);
      add_cmd(CMD_POP_REAR, $urandom);
      add_cmd(CMD_PUSH_FRONT, 32'h8000_0000);
      add_cmd(CMD_POP_REAR, $urandom);
      add_cmd(CMD_PUSH_REAR, 32'h7fff_ffff);
      add_cmd(CMD_PUSH_FRONT, 32'hffff_ffff);
      add_cmd(CMD_PUSH_FRONT, 32'h0000_0000);
      add_cmd(CMD_PUSH_REAR, 32'h5555_5555);
      add_cmd(CMD_PUSH_REAR, 32'haaaa_aaaa);
      add_cmd(CMD_PUSH_FRONT, 32'h1234_5678);
      add_cmd(CMD_PUSH_REAR, 32'h0000_0001);
      add_cmd(CMD_PUSH_FRONT, 32'hfedc_ba98);
      add_cmd(CMD_PUSH_REAR, $urandom);
      add_cmd(CMD_PUSH_FRONT, $urandom);
      for (int i = 0; i < 8; i++) begin
         add_cmd(i[0] ? CMD_POP_REAR : CMD_POP_FRONT, $urandom);
      end
      add_cmd(CMD_POP_FRONT, $urandom);
      add_cmd(CMD_PUSH_REAR, $urandom);
      add_cmd(CMD_POP_FRONT, $urandom);
      wait_drained();

      // receiver holds off while commands keep coming
      @(posedge clock);
      hold_go <= 1'b1;
      add_random(40);
      while (hold_count < HOLD_LEN) @(posedge clock);
      hold_go <= 1'b0;
      wait_drained();

      set_idling(0, 0);
      add_random(200);
      wait_drained();

      set_idling(80, 0);
      add_random(200);
      wait_drained();

      set_idling(0, 80);
      add_random(200);
      wait_drained();

      set_idling(12, 12);
      add_random(200);
      wait_drained();

      repeat (SETTLE_CYC) @(posedge clock);
      $display("%0d commands, %0d responses checked over four idling mixes and a long hold",
               cmd_count, rsp_count);
      $display("refused on full %0d, refused on empty %0d, last-element pops %0d",
               full_refusals, empty_refusals, last_pops);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/cdeq_pkg.sv
rtl/cdeq_ctrl.sv
rtl/cdeq_dpath.sv
rtl/circular_double_ended_queue_core.sv
rtl/cdeq_checker.sv
verif/circular_double_ended_queue_core_tb.sv
